/* sv/dqe_pkg.sv */
// Shared types and constants for the double-ended queue.
// Depends on nothing; the front end, queue, back end, top and testbench import it.
package dqe_pkg;

    localparam int WORD_W      = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_POP_FRONT  = 3'd1,
        CMD_PUSH_BACK  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_READ_ALL   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        FR_IDLE  = 1'b0,
        FR_SWEEP = 1'b1
    } fr_state_t;

    // Control part of one back-end operation.
    typedef struct packed {
        logic    wr;
        logic    rd;
        status_t status;
        logic    last;
    } op_ctrl_t;

endpackage

/* sv/dqe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module dqe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/dqe_front.sv */
// Front end: accepts commands, keeps front index and count, issues operations.
// Depends on dqe_pkg.
module dqe_front import dqe_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [2:0]               command,
    input  logic [WORD_W-1:0]        value,
    output logic                     busy,
    input  logic                     q_full,
    output logic                     op_valid,
    output op_ctrl_t                 op_ctrl,
    output logic [$clog2(DEPTH)-1:0] op_addr,
    output logic [WORD_W-1:0]        op_wdata
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = IW + 2;

    fr_state_t     state_reg, state_next;
    logic [IW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] off_reg, off_next;
    logic [CW-1:0] off_plus;
    logic          accept;
    cmd_t          cmd;

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(DEPTH))
        begin
            s = s - SW'(DEPTH);
        end
        return s[IW-1:0];
    endfunction

    assign busy     = (state_reg == FR_SWEEP) || q_full;
    assign accept   = start && !busy;
    assign cmd      = cmd_t'(command);
    assign off_plus = off_reg + CW'(1);

    // Next state: a read of more than one entry sweeps the rest.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE:
            begin
                if (accept && cmd == CMD_READ_ALL && count_reg > CW'(1))
                begin
                    state_next = FR_SWEEP;
                end
            end
            FR_SWEEP:
            begin
                if (!q_full && off_plus == count_reg)
                begin
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    always_comb
    begin
        op_valid       = 1'b0;
        op_ctrl.wr     = 1'b0;
        op_ctrl.rd     = 1'b0;
        op_ctrl.status = ST_OK;
        op_ctrl.last   = 1'b1;
        op_addr        = front_reg;
        op_wdata       = value;
        front_next     = front_reg;
        count_next     = count_reg;
        off_next       = off_reg;
        case (state_reg)
            FR_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            op_valid = 1'b1;
                            if (count_reg == CW'(DEPTH))
                            begin
                                op_ctrl.status = ST_FULL;
                            end
                            else
                            begin
                                op_ctrl.wr = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (cmd == CMD_PUSH_FRONT)
                                begin
                                    front_next = (front_reg == '0) ? IW'(DEPTH - 1)
                                                                   : front_reg - IW'(1);
                                    op_addr    = front_next;
                                end
                                else
                                begin
                                    op_addr = slot_of(front_reg, count_reg);
                                end
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK:
                        begin
                            op_valid = 1'b1;
                            if (count_reg == '0)
                            begin
                                op_ctrl.status = ST_EMPTY;
                            end
                            else
                            begin
                                op_ctrl.rd = 1'b1;
                                count_next = count_reg - CW'(1);
                                if (cmd == CMD_POP_FRONT)
                                begin
                                    op_addr    = front_reg;
                                    front_next = slot_of(front_reg, CW'(1));
                                end
                                else
                                begin
                                    op_addr = slot_of(front_reg, count_reg - CW'(1));
                                end
                            end
                        end
                        CMD_READ_ALL:
                        begin
                            op_valid = 1'b1;
                            if (count_reg == '0)
                            begin
                                op_ctrl.status = ST_EMPTY;
                            end
                            else
                            begin
                                op_ctrl.rd   = 1'b1;
                                op_addr      = front_reg;
                                op_ctrl.last = (count_reg == CW'(1));
                                off_next     = CW'(1);
                            end
                        end
                        default:
                        begin
                            op_valid = 1'b0;
                        end
                    endcase
                end
            end
            FR_SWEEP:
            begin
                // Advance one entry per cycle while the queue has room.
                if (!q_full)
                begin
                    op_valid     = 1'b1;
                    op_ctrl.rd   = 1'b1;
                    op_addr      = slot_of(front_reg, off_reg);
                    op_ctrl.last = (off_plus == count_reg);
                    off_next     = off_plus;
                end
            end
            default:
            begin
                op_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            off_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            off_reg   <= off_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_sweep_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FR_SWEEP) |-> (busy && off_reg < count_reg))
        else $error("sweep not holding off commands or offset out of range");

endmodule

/* sv/dqe_queue.sv */
// Short operation queue between front end and back end.
// Depends on dqe_pkg.
module dqe_queue import dqe_pkg::*; #(
    parameter int AW = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  op_ctrl_t          in_ctrl,
    input  logic [AW-1:0]     in_addr,
    input  logic [WORD_W-1:0] in_wdata,
    output logic              full,
    input  logic              pop,
    output logic              out_valid,
    output op_ctrl_t          out_ctrl,
    output logic [AW-1:0]     out_addr,
    output logic [WORD_W-1:0] out_wdata
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    op_ctrl_t          ctrl_mem [QUEUE_DEPTH];
    logic [AW-1:0]     addr_mem [QUEUE_DEPTH];
    logic [WORD_W-1:0] data_mem [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]     cnt_reg, cnt_next;
    logic              do_pop;

    assign full      = (cnt_reg == NW'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign do_pop    = pop && out_valid;
    assign out_ctrl  = ctrl_mem[rd_ptr_reg];
    assign out_addr  = addr_mem[rd_ptr_reg];
    assign out_wdata = data_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + NW'(1);
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctrl_mem[wr_ptr_reg] <= in_ctrl;
            addr_mem[wr_ptr_reg] <= in_addr;
            data_mem[wr_ptr_reg] <= in_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("operation pushed into a full queue");

endmodule

/* sv/dqe_back.sv */
// Back end: runs queued operations against the entry RAM and drives results.
// Depends on dqe_pkg and dqe_ram.
module dqe_back import dqe_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     op_valid,
    input  op_ctrl_t                 op_ctrl,
    input  logic [$clog2(DEPTH)-1:0] op_addr,
    input  logic [WORD_W-1:0]        op_wdata,
    output logic                     op_pop,
    output logic                     strobe,
    output logic [1:0]               status,
    output logic signed [WORD_W-1:0] data,
    output logic                     last
);

    logic              strobe_reg;
    status_t           status_reg;
    logic              last_reg;
    logic              rd_reg;
    logic [WORD_W-1:0] ram_rdata;

    // Results cannot be held off, so drain one operation every cycle.
    assign op_pop = op_valid;

    dqe_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (op_valid && op_ctrl.wr),
        .waddr (op_addr),
        .wdata (op_wdata),
        .re    (op_valid && op_ctrl.rd),
        .raddr (op_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        status_reg <= op_ctrl.status;
        last_reg   <= op_ctrl.last;
        rd_reg     <= op_ctrl.rd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= op_valid;
        end
    end

    assign strobe = strobe_reg;
    assign status = status_reg;
    assign last   = last_reg;
    assign data   = rd_reg ? signed'(ram_rdata) : '0;

    a_strobe_follows_op: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(op_valid))
        else $error("result strobe without an operation behind it");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status != ST_OK) |-> (data == '0))
        else $error("non-zero word on a full or empty report");

endmodule

/* sv/double_ended_queue_top.sv */
// Double-ended queue of signed words in a circular buffer. Depends on dqe_pkg, dqe_front, dqe_queue and dqe_back.
// A result strobes once its command has passed through the operation queue and the result registers.
// Push and pop each return one result; read all of n entries returns n words, front
// first, and holds busy while it sweeps the rest, one entry per cycle while the
// operation queue has room, as the entry RAM has a single read port.
// Reset clears front index and count; RAM contents stay undefined until written.
module double_ended_queue_top import dqe_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               command,
    input  logic signed [WORD_W-1:0] value,
    output logic                     strobe,
    output logic [1:0]               status,
    output logic signed [WORD_W-1:0] data,
    output logic                     last
);

    localparam int AW = $clog2(DEPTH);

    logic              f_valid;
    op_ctrl_t          f_ctrl;
    logic [AW-1:0]     f_addr;
    logic [WORD_W-1:0] f_wdata;
    logic              q_full;
    logic              q_valid;
    op_ctrl_t          q_ctrl;
    logic [AW-1:0]     q_addr;
    logic [WORD_W-1:0] q_wdata;
    logic              q_pop;

    dqe_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .command  (command),
        .value    ($unsigned(value)),
        .busy     (busy),
        .q_full   (q_full),
        .op_valid (f_valid),
        .op_ctrl  (f_ctrl),
        .op_addr  (f_addr),
        .op_wdata (f_wdata)
    );

    dqe_queue #(
        .AW (AW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .in_ctrl   (f_ctrl),
        .in_addr   (f_addr),
        .in_wdata  (f_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_ctrl  (q_ctrl),
        .out_addr  (q_addr),
        .out_wdata (q_wdata)
    );

    dqe_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (q_valid),
        .op_ctrl  (q_ctrl),
        .op_addr  (q_addr),
        .op_wdata (q_wdata),
        .op_pop   (q_pop),
        .strobe   (strobe),
        .status   (status),
        .data     (data),
        .last     (last)
    );

endmodule

/* test/tb_double_ended_queue_top.sv */
// Testbench for double_ended_queue_top: random and directed commands, checked
// against a behavioural deque held in the bench. Depends on dqe_pkg and the RTL.
module tb_double_ended_queue_top;
    import dqe_pkg::*;

    localparam int DEPTH = 16;
    localparam int TAIL_CYCLES = 8;
    localparam int ITEM_TARGET = 400;
    localparam int MAX_REPORTS = 10;
    localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CMD_LAST_UNUSED = 3'd7;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic [2:0]               cmd;
        logic signed [WORD_W-1:0] word;
        int unsigned              gap;
        bit                       wait_drain;
    } cmd_item_t;

    typedef struct {
        status_t                  status;
        logic signed [WORD_W-1:0] data;
        logic                     last;
    } deque_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [2:0]               command = CMD_PUSH_FRONT;
    logic signed [WORD_W-1:0] value = '0;
    logic                     busy;
    logic                     strobe;
    logic [1:0]               status;
    logic signed [WORD_W-1:0] data;
    logic                     last;

    cmd_item_t     cmd_backlog[$];
    deque_result_t due_results[$];

    logic signed [WORD_W-1:0] shadow_entries[DEPTH];
    int                       shadow_front = 0;
    int                       shadow_count = 0;

    bit          took_word = 1'b0;
    int unsigned gap_left = 0;
    int          error_count = 0;
    int          stim_count = 0;

    double_ended_queue_top #(.DEPTH(DEPTH)) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .value   (value),
        .strobe  (strobe),
        .status  (status),
        .data    (data),
        .last    (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void due_add(input status_t st, input logic signed [WORD_W-1:0] d,
                                    input logic lst);
        deque_result_t r;
        r.status = st;
        r.data = d;
        r.last = lst;
        due_results.push_back(r);
    endfunction

    function automatic void deque_predict(input logic [2:0] cmd,
                                          input logic signed [WORD_W-1:0] word);
        int slot;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (shadow_count == DEPTH)
                    due_add(ST_FULL, '0, 1'b1);
                else
                begin
                    if (cmd == CMD_PUSH_FRONT)
                    begin
                        shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                        shadow_entries[shadow_front] = word;
                    end
                    else
                        shadow_entries[(shadow_front + shadow_count) % DEPTH] = word;
                    shadow_count++;
                    due_add(ST_OK, '0, 1'b1);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (shadow_count == 0)
                    due_add(ST_EMPTY, '0, 1'b1);
                else
                begin
                    if (cmd == CMD_POP_FRONT)
                    begin
                        slot = shadow_front;
                        shadow_front = (shadow_front + 1) % DEPTH;
                    end
                    else
                        slot = (shadow_front + shadow_count - 1) % DEPTH;
                    shadow_count--;
                    due_add(ST_OK, shadow_entries[slot], 1'b1);
                end
            end
            CMD_READ_ALL:
            begin
                if (shadow_count == 0)
                    due_add(ST_EMPTY, '0, 1'b1);
                else
                    for (int k = 0; k < shadow_count; k++)
                        due_add(ST_OK, shadow_entries[(shadow_front + k) % DEPTH],
                                k == shadow_count - 1);
            end
            default:
                ; // unused codes: no word out, no state change
        endcase
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_item(input logic [2:0] cmd, input logic signed [WORD_W-1:0] w,
                                     input bit calm, input bit drain);
        cmd_item_t it;
        it.cmd = cmd;
        it.word = w;
        it.gap = calm ? 0 : $urandom_range(0, 12);
        it.wait_drain = drain;
        cmd_backlog.push_back(it);
        if (cmd <= CMD_READ_ALL)
            stim_count++;
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, msg);
    endfunction

    // Check returned words, then log the command taken at this edge.
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && strobe === 1'b1)
        begin
            if (due_results.size() == 0)
                note_error($sformatf("unexpected word status=%0d data=%0d last=%0b",
                                     status, data, last));
            else
            begin
                want = due_results.pop_front();
                if (status !== want.status || data !== want.data || last !== want.last)
                    note_error($sformatf(
                        "expected status=%0d data=%0d last=%0b, got status=%0d data=%0d last=%0b",
                        want.status, want.data, want.last, status, data, last));
            end
        end
        took_word = rst_n && start && (busy === 1'b0);
        if (took_word)
            deque_predict(command, value);
    end

    // Present the next word; keep start high across back-to-back words.
    always @(negedge clk)
    begin
        logic                     nxt_start;
        logic [2:0]               nxt_cmd;
        logic signed [WORD_W-1:0] nxt_word;
        nxt_start = start;
        nxt_cmd = command;
        nxt_word = value;
        if (rst_n)
        begin
            if (start && took_word)
            begin
                cmd_backlog.delete(0);
                nxt_start = 1'b0;
                if (cmd_backlog.size() != 0)
                    gap_left = cmd_backlog[0].gap;
            end
            if (!nxt_start && cmd_backlog.size() != 0)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if (!cmd_backlog[0].wait_drain || due_results.size() == 0)
                begin
                    nxt_start = 1'b1;
                    nxt_cmd = cmd_backlog[0].cmd;
                    nxt_word = cmd_backlog[0].word;
                end
            end
        end
        start <= nxt_start;
        command <= nxt_cmd;
        value <= nxt_word;
    end

    initial
    begin
        int  seg;
        int  n;
        bit  calm;
        bit  drain_next;
        logic [2:0] cmd;

        // empty queue cases, then mixed pushes, unused codes and pops
        add_item(CMD_POP_FRONT, pick_word(), 1'b0, 1'b0);
        add_item(CMD_POP_BACK, pick_word(), 1'b0, 1'b0);
        add_item(CMD_READ_ALL, pick_word(), 1'b0, 1'b0);
        add_item(CMD_PUSH_BACK, WORD_MAX, 1'b1, 1'b0);
        add_item(CMD_PUSH_FRONT, WORD_MIN, 1'b1, 1'b0);
        add_item(CMD_PUSH_BACK, -1, 1'b1, 1'b0);
        add_item(CMD_PUSH_FRONT, '0, 1'b1, 1'b0);
        add_item(CMD_READ_ALL, '0, 1'b1, 1'b0);
        for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_UNUSED; c++)
            add_item(c[2:0], $urandom, 1'b0, 1'b0);
        add_item(CMD_POP_FRONT, pick_word(), 1'b0, 1'b0);
        add_item(CMD_POP_BACK, pick_word(), 1'b1, 1'b0);
        add_item(CMD_PUSH_FRONT, 32'sh5A5A_5A5A, 1'b0, 1'b0);
        // hold off until the queue's words have all come back
        add_item(CMD_READ_ALL, '0, 1'b0, 1'b1);
        add_item(CMD_POP_BACK, '0, 1'b1, 1'b0);
        add_item(CMD_POP_BACK, '0, 1'b1, 1'b0);
        add_item(CMD_POP_BACK, '0, 1'b0, 1'b0);
        add_item(CMD_POP_FRONT, '0, 1'b0, 1'b0);

        // fill past full, read out, drain past empty
        for (int k = 0; k < DEPTH + 2; k++)
            add_item($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_word(),
                     1'b0, 1'b0);
        add_item(CMD_READ_ALL, '0, 1'b0, 1'b0);
        for (int k = 0; k < DEPTH + 2; k++)
            add_item($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, pick_word(),
                     1'b0, 1'b0);

        while (stim_count < ITEM_TARGET)
        begin
            seg = $urandom_range(0, 9);
            calm = ($urandom_range(0, 2) == 0);
            n = $urandom_range(1, DEPTH + 4);
            if (seg <= 3)
                for (int k = 0; k < n; k++)
                    add_item($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                             pick_word(), calm, 1'b0);
            else if (seg <= 6)
                for (int k = 0; k < n; k++)
                    add_item($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK,
                             pick_word(), calm, 1'b0);
            else if (seg == 7)
                add_item(CMD_READ_ALL, pick_word(), calm, 1'b0);
            else if (seg == 8)
                for (int k = 0; k < (n % 8) + 1; k++)
                begin
                    cmd = 3'($urandom_range(0, CMD_LAST_UNUSED));
                    add_item(cmd, pick_word(), calm, 1'b0);
                end
            else
            begin
                drain_next = 1'b1;
                add_item(CMD_READ_ALL, pick_word(), calm, drain_next);
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmd_backlog.size() != 0 || start)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && due_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
